// File: sv/llge_pkg.sv
package llge_pkg;

   localparam int MAX_AXIS_DEF   = 32;
   localparam int NUM_AXES_DEF   = 3;
   localparam int STATE_BITS_DEF = 8;

   localparam int MASK_BITS   = 27;
   localparam int SIZE_BITS   = 6;
   localparam int GENS_BITS   = 8;
   localparam int POS_BITS    = 5;
   localparam int NEWST_BITS  = 8;
   localparam int POP_BITS    = 16;
   localparam int CSR_IDX_BITS = 3;

   // neighbor scan: 27 reads, then one drain step and one write-back step
   localparam int NBR_READS  = 27;
   localparam int PHASE_BITS = 5;

   typedef enum logic [1:0] {
      REQ_WRITE   = 2'd0,
      REQ_READ    = 2'd1,
      REQ_ADVANCE = 2'd2,
      REQ_NONE    = 2'd3
   } llge_req_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SIZE_X  = 3'd0,
      CSR_SIZE_Y  = 3'd1,
      CSR_SIZE_Z  = 3'd2,
      CSR_BORN    = 3'd3,
      CSR_SURVIVE = 3'd4,
      CSR_GENS    = 3'd5
   } llge_csr_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_RD_WAIT,
      S_GEN,
      S_RESP
   } llge_state_type;

   typedef struct packed {
      logic issue;
      logic center;
      logic start;
   } llge_nbr_ctl_type;

endpackage

// File: sv/life_like_grid_engine_core.sv
// In-grid write/read: the accepted item passes S_RD_WAIT and S_RESP before its result is
// registered; out-of-grid write/read, unknown request or advance with gens_per_step = 0 go straight to S_RESP.
// Advance: each in-grid cell per generation takes 27 neighbor reads through one RAM
// read port, one drain and one write-back, for every cell of the grid and every generation.
// One item is worked at a time; the next is taken once its result is in the output register.
// Reset (synchronous, active high) and any size register write start a clearing pass over
// every RAM address of both buffers, during which no item is accepted.
module life_like_grid_engine_core
   import llge_pkg::*;
#(
   parameter int MAX_AXIS   = MAX_AXIS_DEF,
   parameter int NUM_AXES   = NUM_AXES_DEF,
   parameter int STATE_BITS = STATE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // pos_x[4:0], pos_y[9:5], pos_z[14:10], new_state[22:15]
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // read_state[7:0], population[23:8]
   output logic [0:0]  rsp_tuser,   // error_flag[0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [MASK_BITS-1:0]    csr_data
);

   localparam int AW    = $clog2(MAX_AXIS);
   localparam int SW    = $clog2(MAX_AXIS + 1);
   localparam int ABITS = AW * NUM_AXES;
   localparam int DEPTH = 2 ** ABITS;
   localparam int CELLS = MAX_AXIS ** NUM_AXES;
   localparam int LCW   = $clog2(CELLS + 1);
   localparam int NW    = AW + 2;

   function automatic logic [ABITS-1:0] cell_addr(input logic [AW-1:0] x,
                                                  input logic [AW-1:0] y,
                                                  input logic [AW-1:0] z);
      if (NUM_AXES == 3) begin
         cell_addr = ABITS'({x, y, z});
      end else begin
         cell_addr = ABITS'({x, y});
      end
   endfunction

   function automatic logic [SW-1:0] eff_size(input logic [SIZE_BITS-1:0] v);
      if (v == '0) begin
         eff_size = SW'(1);
      end else if (int'(v) > MAX_AXIS) begin
         eff_size = SW'(MAX_AXIS);
      end else begin
         eff_size = SW'(v);
      end
   endfunction

   llge_state_type         state_ff, state_in;
   logic [SIZE_BITS-1:0]   size_x_ff, size_x_in, size_y_ff, size_y_in, size_z_ff, size_z_in;
   logic [MASK_BITS-1:0]   born_ff, born_in, survive_ff, survive_in;
   logic [GENS_BITS-1:0]   gens_ff, gens_in;
   logic [1:0]             type_ff, type_in;
   logic [AW-1:0]          x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [STATE_BITS-1:0]  ns_ff, ns_in;
   logic [7:0]             res_rd_ff, res_rd_in;
   logic                   res_err_ff, res_err_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_rd_ff, rsp_rd_in;
   logic [POP_BITS-1:0]    rsp_pop_ff, rsp_pop_in;
   logic                   rsp_err_ff, rsp_err_in;
   logic [LCW-1:0]         live_ff, live_in, pop_ff, pop_in;
   logic                   bufsel_ff, bufsel_in;
   logic [ABITS-1:0]       clr_ff, clr_in;
   logic [AW-1:0]          cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic [1:0]             ox_ff, ox_in, oy_ff, oy_in, oz_ff, oz_in;
   logic [PHASE_BITS-1:0]  phase_ff, phase_in;
   logic [GENS_BITS-1:0]   gen_ff, gen_in;

   logic [SW-1:0]          sx, sy, sz;
   logic [POS_BITS-1:0]    req_x, req_y, req_z;
   logic                   req_in_grid;
   logic [NW-1:0]          nx, ny, nz;
   logic                   nbr_in_grid;
   logic                   we0, we1;
   logic [ABITS-1:0]       waddr, raddr;
   logic [STATE_BITS-1:0]  wdata, rdata0, rdata1, rdata_cur;
   llge_nbr_ctl_type       nbr_ctl;
   logic                   next_alive;
   logic                   wr_cur, wr_nxt, last_cell;

   assign sx = eff_size(size_x_ff);
   assign sy = eff_size(size_y_ff);
   assign sz = (NUM_AXES < 3) ? SW'(1) : eff_size(size_z_ff);

   assign req_x = req_tdata[4:0];
   assign req_y = req_tdata[9:5];
   assign req_z = req_tdata[14:10];
   assign req_in_grid = (8'(req_x) < 8'(sx)) && (8'(req_y) < 8'(sy)) && (8'(req_z) < 8'(sz));

   // neighbor coordinate plus one, so zero marks the low edge
   assign nx = NW'(cx_ff) + NW'(ox_ff);
   assign ny = NW'(cy_ff) + NW'(oy_ff);
   assign nz = NW'(cz_ff) + NW'(oz_ff);
   assign nbr_in_grid = (nx != '0) && (ny != '0) && (nz != '0) &&
                        (8'(nx) <= 8'(sx)) && (8'(ny) <= 8'(sy)) && (8'(nz) <= 8'(sz));

   assign rdata_cur = bufsel_ff ? rdata1 : rdata0;
   assign last_cell = (SW'(cz_ff) == sz - SW'(1)) && (SW'(cy_ff) == sy - SW'(1)) &&
                      (SW'(cx_ff) == sx - SW'(1));

   always_comb begin
      state_in     = state_ff;
      size_x_in    = size_x_ff;
      size_y_in    = size_y_ff;
      size_z_in    = size_z_ff;
      born_in      = born_ff;
      survive_in   = survive_ff;
      gens_in      = gens_ff;
      type_in      = type_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      ns_in        = ns_ff;
      res_rd_in    = res_rd_ff;
      res_err_in   = res_err_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_rd_in    = rsp_rd_ff;
      rsp_pop_in   = rsp_pop_ff;
      rsp_err_in   = rsp_err_ff;
      live_in      = live_ff;
      pop_in       = pop_ff;
      bufsel_in    = bufsel_ff;
      clr_in       = clr_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      oz_in        = oz_ff;
      phase_in     = phase_ff;
      gen_in       = gen_ff;
      req_tready   = 1'b0;
      wr_cur       = 1'b0;
      wr_nxt       = 1'b0;
      waddr        = cell_addr(x_ff, y_ff, z_ff);
      wdata        = ns_ff;
      raddr        = cell_addr(x_ff, y_ff, z_ff);
      nbr_ctl      = '0;
      we0          = 1'b0;
      we1          = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            we0    = 1'b1;
            we1    = 1'b1;
            waddr  = clr_ff;
            wdata  = '0;
            clr_in = clr_ff + ABITS'(1);
            if (clr_ff == {ABITS{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            raddr = cell_addr(AW'(req_x), AW'(req_y), AW'(req_z));
            if (req_tvalid) begin
               type_in    = req_tuser;
               x_in       = AW'(req_x);
               y_in       = AW'(req_y);
               z_in       = AW'(req_z);
               ns_in      = STATE_BITS'(req_tdata[22:15]);
               res_rd_in  = '0;
               res_err_in = 1'b0;
               case (llge_req_type'(req_tuser))
                  REQ_WRITE, REQ_READ: begin
                     if (req_in_grid) begin
                        state_in = S_RD_WAIT;
                     end else begin
                        res_err_in = 1'b1;
                        state_in   = S_RESP;
                     end
                  end
                  REQ_ADVANCE: begin
                     cx_in    = '0;
                     cy_in    = '0;
                     cz_in    = '0;
                     ox_in    = '0;
                     oy_in    = '0;
                     oz_in    = '0;
                     phase_in = '0;
                     gen_in   = '0;
                     pop_in   = '0;
                     state_in = (gens_ff == '0) ? S_RESP : S_GEN;
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_RD_WAIT: begin
            if (llge_req_type'(type_ff) == REQ_WRITE) begin
               wr_cur = 1'b1;
               if ((rdata_cur == '0) && (ns_ff != '0)) begin
                  live_in = live_ff + LCW'(1);
               end else if ((rdata_cur != '0) && (ns_ff == '0)) begin
                  live_in = live_ff - LCW'(1);
               end
            end else begin
               res_rd_in = 8'(rdata_cur);
            end
            state_in = S_RESP;
         end
         S_GEN: begin
            raddr = cell_addr(AW'(nx - NW'(1)), AW'(ny - NW'(1)), AW'(nz - NW'(1)));
            if (phase_ff < PHASE_BITS'(NBR_READS)) begin
               nbr_ctl.issue  = nbr_in_grid;
               nbr_ctl.center = (ox_ff == 2'd1) && (oy_ff == 2'd1) && (oz_ff == 2'd1);
               phase_in = phase_ff + PHASE_BITS'(1);
               oz_in = (oz_ff == 2'd2) ? 2'd0 : oz_ff + 2'd1;
               if (oz_ff == 2'd2) begin
                  oy_in = (oy_ff == 2'd2) ? 2'd0 : oy_ff + 2'd1;
                  if (oy_ff == 2'd2) begin
                     ox_in = (ox_ff == 2'd2) ? 2'd0 : ox_ff + 2'd1;
                  end
               end
            end else if (phase_ff == PHASE_BITS'(NBR_READS)) begin
               // drain: last read lands in the accumulator
               phase_in = phase_ff + PHASE_BITS'(1);
            end else begin
               wr_nxt        = 1'b1;
               waddr         = cell_addr(cx_ff, cy_ff, cz_ff);
               wdata         = next_alive ? STATE_BITS'(1) : '0;
               nbr_ctl.start = 1'b1;
               phase_in      = '0;
               pop_in        = pop_ff + LCW'(next_alive);
               // advance to the next cell, z fastest
               if (SW'(cz_ff) == sz - SW'(1)) begin
                  cz_in = '0;
                  if (SW'(cy_ff) == sy - SW'(1)) begin
                     cy_in = '0;
                     cx_in = (SW'(cx_ff) == sx - SW'(1)) ? '0 : cx_ff + AW'(1);
                  end else begin
                     cy_in = cy_ff + AW'(1);
                  end
               end else begin
                  cz_in = cz_ff + AW'(1);
               end
               if (last_cell) begin
                  live_in   = pop_ff + LCW'(next_alive);
                  pop_in    = '0;
                  bufsel_in = ~bufsel_ff;
                  gen_in    = gen_ff + GENS_BITS'(1);
                  if (gen_ff + GENS_BITS'(1) == gens_ff) begin
                     state_in = S_RESP;
                  end
               end
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_rd_in    = res_rd_ff;
               rsp_pop_in   = POP_BITS'(live_ff);
               rsp_err_in   = res_err_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase

      we0 = we0 | (wr_cur & ~bufsel_ff) | (wr_nxt & bufsel_ff);
      we1 = we1 | (wr_cur & bufsel_ff) | (wr_nxt & ~bufsel_ff);

      if (csr_valid) begin
         case (llge_csr_type'(csr_index))
            CSR_SIZE_X, CSR_SIZE_Y, CSR_SIZE_Z: begin
               if (llge_csr_type'(csr_index) == CSR_SIZE_X) size_x_in = csr_data[SIZE_BITS-1:0];
               if (llge_csr_type'(csr_index) == CSR_SIZE_Y) size_y_in = csr_data[SIZE_BITS-1:0];
               if (llge_csr_type'(csr_index) == CSR_SIZE_Z) size_z_in = csr_data[SIZE_BITS-1:0];
               live_in  = '0;
               clr_in   = '0;
               state_in = S_CLEAR;
            end
            CSR_BORN:    born_in    = csr_data;
            CSR_SURVIVE: survive_in = csr_data;
            CSR_GENS:    gens_in    = csr_data[GENS_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         size_x_ff    <= SIZE_BITS'(30);
         size_y_ff    <= SIZE_BITS'(30);
         size_z_ff    <= SIZE_BITS'(30);
         born_ff      <= MASK_BITS'(48);
         survive_ff   <= MASK_BITS'(32);
         gens_ff      <= GENS_BITS'(1);
         rsp_valid_ff <= 1'b0;
         live_ff      <= '0;
         pop_ff       <= '0;
         bufsel_ff    <= 1'b0;
         clr_ff       <= '0;
         cx_ff        <= '0;
         cy_ff        <= '0;
         cz_ff        <= '0;
         ox_ff        <= '0;
         oy_ff        <= '0;
         oz_ff        <= '0;
         phase_ff     <= '0;
         gen_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         size_x_ff    <= size_x_in;
         size_y_ff    <= size_y_in;
         size_z_ff    <= size_z_in;
         born_ff      <= born_in;
         survive_ff   <= survive_in;
         gens_ff      <= gens_in;
         rsp_valid_ff <= rsp_valid_in;
         live_ff      <= live_in;
         pop_ff       <= pop_in;
         bufsel_ff    <= bufsel_in;
         clr_ff       <= clr_in;
         cx_ff        <= cx_in;
         cy_ff        <= cy_in;
         cz_ff        <= cz_in;
         ox_ff        <= ox_in;
         oy_ff        <= oy_in;
         oz_ff        <= oz_in;
         phase_ff     <= phase_in;
         gen_ff       <= gen_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff    <= type_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      z_ff       <= z_in;
      ns_ff      <= ns_in;
      res_rd_ff  <= res_rd_in;
      res_err_ff <= res_err_in;
      rsp_rd_ff  <= rsp_rd_in;
      rsp_pop_ff <= rsp_pop_in;
      rsp_err_ff <= rsp_err_in;
   end

   llge_ram #(.WIDTH(STATE_BITS), .DEPTH(DEPTH)) u_buf0 (
      .clock (clock),
      .we    (we0),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata0)
   );

   llge_ram #(.WIDTH(STATE_BITS), .DEPTH(DEPTH)) u_buf1 (
      .clock (clock),
      .we    (we1),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata1)
   );

   llge_nbr_acc u_nbr (
      .clock        (clock),
      .reset        (reset),
      .ctl          (nbr_ctl),
      .rdata_live   (rdata_cur != '0),
      .born_mask    (born_ff),
      .survive_mask (survive_ff),
      .next_alive   (next_alive)
   );

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_pop_ff, rsp_rd_ff};
   assign rsp_tuser  = rsp_err_ff;

   a_reset_clears: assert property (@(posedge clock) reset |=> state_ff == S_CLEAR)
      else $error("reset did not start the clearing pass");

   a_size_write_clears: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && (llge_csr_type'(csr_index) == CSR_SIZE_X ||
                     llge_csr_type'(csr_index) == CSR_SIZE_Y ||
                     llge_csr_type'(csr_index) == CSR_SIZE_Z))
      |=> (state_ff == S_CLEAR && live_ff == '0))
      else $error("size write did not clear the grid");

   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= LCW'(CELLS))
      else $error("live count above cell count");

   a_phase_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PHASE_BITS'(NBR_READS + 1))
      else $error("neighbor phase out of range");

   a_gen_flip: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GEN && wr_nxt && last_cell && !csr_valid)
      |=> bufsel_ff != $past(bufsel_ff))
      else $error("buffer select did not flip at end of generation");

endmodule

// File: sv/llge_ram.sv
module llge_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/llge_nbr_acc.sv
module llge_nbr_acc
   import llge_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  llge_nbr_ctl_type       ctl,
   input  logic                   rdata_live,
   input  logic [MASK_BITS-1:0]   born_mask,
   input  logic [MASK_BITS-1:0]   survive_mask,
   output logic                   next_alive
);

   logic                  issue_ff, issue_in;
   logic                  center_ff, center_in;
   logic [PHASE_BITS-1:0] cnt_ff, cnt_in;
   logic                  live_ff, live_in;

   always_comb begin
      issue_in  = ctl.issue;
      center_in = ctl.center;
      cnt_in    = cnt_ff;
      live_in   = live_ff;
      // read data arrives in the cycle after its address is issued
      if (issue_ff && rdata_live) begin
         if (center_ff) begin
            live_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + PHASE_BITS'(1);
         end
      end
      if (ctl.start) begin
         cnt_in  = '0;
         live_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff  <= 1'b0;
         center_ff <= 1'b0;
         cnt_ff    <= '0;
         live_ff   <= 1'b0;
      end else begin
         issue_ff  <= issue_in;
         center_ff <= center_in;
         cnt_ff    <= cnt_in;
         live_ff   <= live_in;
      end
   end

   assign next_alive = live_ff ? survive_mask[cnt_ff] : born_mask[cnt_ff];

endmodule

// File: tb/life_like_grid_engine_core_test.sv
`timescale 1ns / 1ps

module life_like_grid_engine_core_test;
   import llge_pkg::*;

   localparam int GRID_CELLS = 32768;
   localparam longint CYCLE_LIMIT = 5000000;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED_IDX = 3'd7;

   typedef struct {
      logic [7:0]  read_state;
      logic [15:0] population;
      logic        error_flag;
   } cell_result_type;

   typedef struct {
      llge_req_type    kind;
      logic [4:0]      pos_x;
      logic [4:0]      pos_y;
      logic [4:0]      pos_z;
      logic [7:0]      new_state;
      logic            known;
      cell_result_type want;
   } grid_row_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [23:0] req_tdata;
   logic [1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [23:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [MASK_BITS-1:0] csr_data;

   // predicted grid, both buffers, and its shadow configuration
   logic [7:0] cells [2][GRID_CELLS];
   logic active_buf;
   logic [15:0] live_cells;
   logic [5:0] ext_x_reg, ext_y_reg, ext_z_reg;
   logic [26:0] born_bits, survive_bits;
   logic [7:0] gens_reg;

   cell_result_type pending_results[$];
   int mismatches = 0;
   longint cycle_count = 0;
   int burst_left;
   int hold_ticket, hold_seen = 0, hold_cnt;

   life_like_grid_engine_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int extent(input logic [5:0] v);
      if (v == 0) return 1;
      if (v > 32) return 32;
      return int'(v);
   endfunction

   function automatic int cell_at(input int x, input int y, input int z);
      return (x * 1024 + y * 32 + z) % GRID_CELLS;
   endfunction

   task automatic clear_cells();
      for (int b = 0; b < 2; b++)
         for (int i = 0; i < GRID_CELLS; i++) cells[b][i] = 8'd0;
      live_cells = 16'd0;
   endtask

   task automatic run_generation();
      int sx, sy, sz, n, pop, nx, ny, nz;
      logic live, nxt;
      sx = extent(ext_x_reg);
      sy = extent(ext_y_reg);
      sz = extent(ext_z_reg);
      pop = 0;
      for (int x = 0; x < sx; x++)
         for (int y = 0; y < sy; y++)
            for (int z = 0; z < sz; z++) begin
               n = 0;
               for (int dx = -1; dx <= 1; dx++)
                  for (int dy = -1; dy <= 1; dy++)
                     for (int dz = -1; dz <= 1; dz++) begin
                        nx = x + dx;
                        ny = y + dy;
                        nz = z + dz;
                        if (!(dx == 0 && dy == 0 && dz == 0) && nx >= 0 && ny >= 0 &&
                            nz >= 0 && nx < sx && ny < sy && nz < sz &&
                            cells[active_buf][cell_at(nx, ny, nz)] != 0)
                           n++;
                     end
               live = cells[active_buf][cell_at(x, y, z)] != 0;
               nxt = live ? survive_bits[n] : born_bits[n];
               cells[~active_buf][cell_at(x, y, z)] = {7'd0, nxt};
               if (nxt) pop++;
            end
      live_cells = pop[15:0];
      active_buf = ~active_buf;
   endtask

   task automatic predict_grid(input llge_req_type kind, input logic [4:0] x,
                               input logic [4:0] y, input logic [4:0] z,
                               input logic [7:0] ns, output cell_result_type res);
      int idx;
      res.read_state = 8'd0;
      res.error_flag = 1'b0;
      if (kind == REQ_WRITE || kind == REQ_READ) begin
         if (x >= extent(ext_x_reg) || y >= extent(ext_y_reg) || z >= extent(ext_z_reg)) begin
            res.error_flag = 1'b1;
         end else begin
            idx = cell_at(x, y, z);
            if (kind == REQ_WRITE) begin
               if (cells[active_buf][idx] == 0 && ns != 0) live_cells++;
               else if (cells[active_buf][idx] != 0 && ns == 0) live_cells--;
               cells[active_buf][idx] = ns;
            end else begin
               res.read_state = cells[active_buf][idx];
            end
         end
      end else if (kind == REQ_ADVANCE) begin
         for (int g = 0; g < gens_reg; g++) run_generation();
      end
      res.population = live_cells;
   endtask

   // hold the item until accepted; bursts with random gaps between them
   task automatic send_cell_req(input grid_row_type row);
      cell_result_type res;
      req_tvalid <= 1'b1;
      req_tuser <= row.kind;
      req_tdata <= {1'b0, row.new_state, row.pos_z, row.pos_y, row.pos_x};
      do @(posedge clock); while (!req_tready);
      predict_grid(row.kind, row.pos_x, row.pos_y, row.pos_z, row.new_state, res);
      pending_results.push_back(row.known ? row.want : res);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(0, 8);
      end else begin
         burst_left--;
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] idx, input logic [26:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SIZE_X: begin ext_x_reg = value[5:0]; clear_cells(); end
         CSR_SIZE_Y: begin ext_y_reg = value[5:0]; clear_cells(); end
         CSR_SIZE_Z: begin ext_z_reg = value[5:0]; clear_cells(); end
         CSR_BORN: born_bits = value;
         CSR_SURVIVE: survive_bits = value;
         CSR_GENS: gens_reg = value[7:0];
         default: ;
      endcase
   endtask

   task automatic random_items(input int count, input int advance_pct, input logic pressure);
      grid_row_type row;
      int r;
      for (int i = 0; i < count; i++) begin
         if (pressure && i == count / 3) hold_ticket++;
         if (pressure && i == 2 * count / 3) wait_drained();
         r = $urandom_range(0, 99);
         row.kind = r < advance_pct ? REQ_ADVANCE : r < advance_pct + 5 ? REQ_NONE :
                    r < 55 + advance_pct / 2 ? REQ_WRITE : REQ_READ;
         // mostly in-grid coordinates, the rest anywhere
         if ($urandom_range(0, 9) < 8) begin
            row.pos_x = 5'($urandom_range(0, extent(ext_x_reg) - 1));
            row.pos_y = 5'($urandom_range(0, extent(ext_y_reg) - 1));
            row.pos_z = 5'($urandom_range(0, extent(ext_z_reg) - 1));
         end else begin
            row.pos_x = 5'($urandom_range(0, 31));
            row.pos_y = 5'($urandom_range(0, 31));
            row.pos_z = 5'($urandom_range(0, 31));
         end
         row.new_state = $urandom_range(0, 9) < 3 ? 8'd0 : 8'($urandom);
         row.known = 1'b0;
         send_cell_req(row);
      end
   endtask

   // check accepted results; stall on a pattern, with one long hold-off on request
   always @(posedge clock) begin
      cell_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_cnt <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h/%b", rsp_tdata, rsp_tuser);
            end else begin
               want = pending_results.pop_front();
               if (rsp_tdata[7:0] !== want.read_state || rsp_tdata[23:8] !== want.population ||
                   rsp_tuser[0] !== want.error_flag) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: read_state %h/%h population %0d/%0d error %b/%b",
                              want.read_state, rsp_tdata[7:0], want.population,
                              rsp_tdata[23:8], want.error_flag, rsp_tuser[0]);
               end
            end
         end
         if (hold_ticket != hold_seen) begin
            hold_seen <= hold_ticket;
            hold_cnt <= 400;
            rsp_tready <= 1'b0;
         end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            rsp_tready <= 1'b0;
         end else if (cycle_count[9:8] == 2'd0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= $urandom_range(0, 3) != 0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      grid_row_type directed[$];
      cell_result_type r;
      logic [4:0] hi;
      hold_ticket = 0;
      burst_left = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = REQ_NONE;
      csr_valid = 1'b0;
      csr_index = CSR_SIZE_X;
      csr_data = '0;
      active_buf = 1'b0;
      ext_x_reg = 6'd30;
      ext_y_reg = 6'd30;
      ext_z_reg = 6'd30;
      born_bits = 27'd48;
      survive_bits = 27'd32;
      gens_reg = 8'd1;
      clear_cells();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // zero generations: an advance on the full grid must leave it alone
      csr_write(CSR_GENS, 27'd0);
      hi = 5'd29;
      directed = '{
         '{REQ_READ, 5'd0, 5'd0, 5'd0, 8'h00, 1'b1, '{8'h00, 16'd0, 1'b0}},
         '{REQ_WRITE, 5'd0, 5'd0, 5'd0, 8'hFF, 1'b1, '{8'h00, 16'd1, 1'b0}},
         '{REQ_READ, 5'd0, 5'd0, 5'd0, 8'h00, 1'b1, '{8'hFF, 16'd1, 1'b0}},
         '{REQ_WRITE, hi, hi, hi, 8'h01, 1'b1, '{8'h00, 16'd2, 1'b0}},
         '{REQ_READ, hi, hi, hi, 8'h00, 1'b1, '{8'h01, 16'd2, 1'b0}},
         '{REQ_WRITE, 5'd30, 5'd0, 5'd0, 8'hAA, 1'b1, '{8'h00, 16'd2, 1'b1}},
         '{REQ_READ, 5'd31, 5'd31, 5'd31, 8'h00, 1'b1, '{8'h00, 16'd2, 1'b1}},
         '{REQ_READ, 5'd0, 5'd30, 5'd0, 8'h00, 1'b1, '{8'h00, 16'd2, 1'b1}},
         '{REQ_WRITE, 5'd0, 5'd0, 5'd31, 8'h80, 1'b1, '{8'h00, 16'd2, 1'b1}},
         '{REQ_WRITE, 5'd0, 5'd0, 5'd0, 8'h55, 1'b1, '{8'h00, 16'd2, 1'b0}},
         '{REQ_WRITE, 5'd0, 5'd0, 5'd0, 8'h00, 1'b1, '{8'h00, 16'd1, 1'b0}},
         '{REQ_NONE, 5'd31, 5'd31, 5'd31, 8'hFF, 1'b1, '{8'h00, 16'd1, 1'b0}},
         '{REQ_WRITE, hi, hi, hi, 8'h00, 1'b1, '{8'h00, 16'd0, 1'b0}},
         '{REQ_ADVANCE, 5'd0, 5'd0, 5'd0, 8'h00, 1'b1, '{8'h00, 16'd0, 1'b0}},
         '{REQ_WRITE, 5'd21, 5'd10, 5'd5, 8'h80, 1'b0, '{8'h00, 16'd0, 1'b0}},
         '{REQ_WRITE, 5'd5, 5'd10, 5'd21, 8'h7F, 1'b0, '{8'h00, 16'd0, 1'b0}},
         '{REQ_READ, 5'd21, 5'd10, 5'd5, 8'h00, 1'b0, '{8'h00, 16'd0, 1'b0}},
         '{REQ_READ, 5'd10, 5'd21, 5'd5, 8'h00, 1'b0, '{8'h00, 16'd0, 1'b0}},
         '{REQ_ADVANCE, 5'd0, 5'd0, 5'd0, 8'h00, 1'b0, '{8'h00, 16'd0, 1'b0}}
      };
      foreach (directed[i]) send_cell_req(directed[i]);
      wait_drained();

      // small 4x4x3 grid, random rules
      csr_write(CSR_SIZE_X, 27'd4);
      csr_write(CSR_SIZE_Y, 27'd4);
      csr_write(CSR_SIZE_Z, 27'd3);
      csr_write(CSR_BORN, 27'($urandom));
      csr_write(CSR_SURVIVE, 27'($urandom));
      csr_write(CSR_GENS, 27'd2);
      random_items(40, 12, 1'b0);
      wait_drained();

      // one row: oversized and zero sizes, extreme masks, with pressure
      csr_write(CSR_SIZE_X, 27'd63);
      csr_write(CSR_SIZE_Y, 27'd0);
      csr_write(CSR_SIZE_Z, 27'd1);
      csr_write(CSR_BORN, 27'h7FFFFFF);
      csr_write(CSR_SURVIVE, 27'd0);
      csr_write(CSR_GENS, 27'd3);
      random_items(35, 10, 1'b1);
      wait_drained();

      // tiny grid, most generations per advance
      csr_write(CSR_SIZE_X, 27'd2);
      csr_write(CSR_SIZE_Y, 27'd2);
      csr_write(CSR_SIZE_Z, 27'd1);
      csr_write(CSR_BORN, 27'd0);
      csr_write(CSR_SURVIVE, 27'h7FFFFFF);
      csr_write(CSR_GENS, 27'd255);
      csr_write(CSR_UNUSED_IDX, 27'h5A5A5A5);
      random_items(30, 8, 1'b0);
      wait_drained();
      repeat (20) @(posedge clock);

      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
